// ===== src/qsr_pkg.sv =====
package qsr_pkg;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } qsr_in_t;

  typedef struct packed {
    logic        [1:0]  root_count;
    logic signed [31:0] first_root;
    logic signed [31:0] second_root;
    logic               overflow;
  } qsr_out_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam logic [15:0] EPS_RESET = 16'd7;

endpackage

// ===== src/qsr_sqrt_cell.sv =====
module qsr_sqrt_cell #(
  parameter int SW     = 32,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_in,
  input  logic [2*SW-1:0]     rad_in,
  input  logic [SW-1:0]       res_in,
  input  logic [SW:0]         rem_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                v_out,
  output logic [2*SW-1:0]     rad_out,
  output logic [SW-1:0]       res_out,
  output logic [SW:0]         rem_out,
  output logic [SIDE_W-1:0]   side_out
);

  logic              valid_r;
  logic [2*SW-1:0]   rad_r, rad_nxt;
  logic [SW-1:0]     res_r, res_nxt;
  logic [SW:0]       rem_r, rem_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [SW+2:0]     shifted;
  logic [SW+2:0]     trial;
  logic              ge;

  // one result bit per cell: bring down two radicand bits, try 4y+1
  always_comb begin
    shifted = {rem_in, rad_in[2*SW-1 -: 2]};
    trial   = {1'b0, res_in, 2'b01};
    ge      = shifted >= trial;
    rem_nxt = ge ? (SW+1)'(shifted - trial) : (SW+1)'(shifted);
    res_nxt = {res_in[SW-2:0], ge};
    rad_nxt = {rad_in[2*SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
    side_r <= side_in;
  end

  assign v_out    = valid_r;
  assign rad_out  = rad_r;
  assign res_out  = res_r;
  assign rem_out  = rem_r;
  assign side_out = side_r;

endmodule

// ===== src/qsr_div_cell.sv =====
module qsr_div_cell #(
  parameter int NW     = 49,
  parameter int DW     = 33,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_in,
  input  logic [NW-1:0]     num_in,
  input  logic [DW-1:0]     rem_in,
  input  logic [DW-1:0]     den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [NW-1:0]     num_out,
  output logic [DW-1:0]     rem_out,
  output logic [DW-1:0]     den_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              valid_r;
  logic [NW-1:0]     num_r, num_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     den_r;
  logic [SIDE_W-1:0] side_r;
  logic [DW:0]       trial;
  logic              ge;

  // restoring step: quotient bits shift in where numerator bits leave
  always_comb begin
    trial   = {rem_in, num_in[NW-1]};
    ge      = trial >= {1'b0, den_in};
    rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    num_nxt = {num_in[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_in;
    side_r <= side_in;
  end

  assign v_out    = valid_r;
  assign num_out  = num_r;
  assign rem_out  = rem_r;
  assign den_out  = den_r;
  assign side_out = side_r;

endmodule

// ===== src/quadratic_root_solver_unit.sv =====
// Real roots of a*x^2+b*x+c in signed fixed point. One item is taken every cycle
// (busy stays low) and its result is strobed by out_valid for one cycle; the
// receiver cannot stall. The pipeline holds three setup stages (magnitudes,
// products, discriminant), a row of COEF_WIDTH square-root cells giving one
// root bit each, a prep stage, two parallel rows of COEF_WIDTH+FRAC_BITS+1
// divider cells giving one quotient bit each, and the output register.
// zero_epsilon is written over the cfg channel, which is always ready; write it
// only while no item is in flight.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qsr_pkg::qsr_in_t  in_item,
  output logic              out_valid,
  output qsr_pkg::qsr_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  import qsr_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int PW  = 2 * W;
  localparam int DW  = W + 1;
  localparam int QW  = W + 1 + FRAC_BITS;
  localparam int DZW = PW + 2 + FRAC_BITS;

  typedef struct packed {
    logic [1:0]   count;
    logic         lin;
    logic [1:0]   rem2;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
    logic         an;
    logic         bn;
    logic         cn;
  } sq_side_t;

  typedef struct packed {
    logic [1:0] count;
    logic       neg;
  } dv_side_t;

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int DV_SW = $bits(dv_side_t);

  function automatic logic [W:0] fin_root(input logic neg, input logic [QW-1:0] q,
                                          input logic [15:0] eps);
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    logic          o;
    logic [W-1:0]  val;
    lim = QW'(1) << (W - 1);
    m   = q;
    o   = 1'b0;
    if (neg) begin
      if (q > lim) begin
        m = lim;
        o = 1'b1;
      end
    end else if (q > lim - QW'(1)) begin
      m = lim - QW'(1);
      o = 1'b1;
    end
    if (m == '0 || m < QW'(eps)) begin
      val = '0;
    end else begin
      val = neg ? W'(QW'(0) - m) : W'(m);
    end
    return {o, val};
  endfunction

  // configuration
  logic [15:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // stage 1: magnitudes and zero tests
  logic         accept;
  logic [W-1:0] a_raw, b_raw, c_raw;
  logic [W-1:0] am_nxt, bm_nxt, cm_nxt;

  assign accept = start && !busy;
  assign a_raw  = in_item.coef_a[W-1:0];
  assign b_raw  = in_item.coef_b[W-1:0];
  assign c_raw  = in_item.coef_c[W-1:0];
  assign am_nxt = a_raw[W-1] ? W'(~a_raw + 1'b1) : a_raw;
  assign bm_nxt = b_raw[W-1] ? W'(~b_raw + 1'b1) : b_raw;
  assign cm_nxt = c_raw[W-1] ? W'(~c_raw + 1'b1) : c_raw;

  logic         s1_valid_r;
  logic [W-1:0] s1_am_r, s1_bm_r, s1_cm_r;
  logic         s1_an_r, s1_bn_r, s1_cn_r;
  logic         s1_az_r, s1_bz_r, s1_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_am_r <= am_nxt;
    s1_bm_r <= bm_nxt;
    s1_cm_r <= cm_nxt;
    s1_an_r <= a_raw[W-1];
    s1_bn_r <= b_raw[W-1];
    s1_cn_r <= c_raw[W-1];
    s1_az_r <= (am_nxt == '0) || (am_nxt < W'(eps_r));
    s1_bz_r <= (bm_nxt == '0) || (bm_nxt < W'(eps_r));
    s1_cz_r <= (cm_nxt == '0) || (cm_nxt < W'(eps_r));
  end

  // stage 2: products
  logic          s2_valid_r;
  logic [PW-1:0] s2_m_r, s2_b2_r;
  logic [W-1:0]  s2_am_r, s2_bm_r, s2_cm_r;
  logic          s2_an_r, s2_bn_r, s2_cn_r;
  logic          s2_az_r, s2_bz_r, s2_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_m_r  <= PW'(s1_am_r) * PW'(s1_cm_r);
    s2_b2_r <= PW'(s1_bm_r) * PW'(s1_bm_r);
    s2_am_r <= s1_am_r;
    s2_bm_r <= s1_bm_r;
    s2_cm_r <= s1_cm_r;
    s2_an_r <= s1_an_r;
    s2_bn_r <= s1_bn_r;
    s2_cn_r <= s1_cn_r;
    s2_az_r <= s1_az_r;
    s2_bz_r <= s1_bz_r;
    s2_cz_r <= s1_cz_r;
  end

  // stage 3: discriminant as 4*q + rem, and case selection
  logic [PW-1:0] b4, q_nxt;
  logic          same_sign, neg_disc, dzero, lin_nxt;
  logic [1:0]    cnt_nxt;
  logic [DZW-1:0] d_full, eps_d;

  always_comb begin
    b4        = s2_b2_r >> 2;
    same_sign = (s2_an_r == s2_cn_r);
    neg_disc  = same_sign && (s2_m_r > b4);
    q_nxt     = same_sign ? PW'(b4 - s2_m_r) : PW'(b4 + s2_m_r);
    d_full    = DZW'({q_nxt, s2_b2_r[1:0]});
    eps_d     = DZW'(eps_r) << FRAC_BITS;
    dzero     = (d_full == '0) || (d_full < eps_d);
    lin_nxt   = 1'b0;
    if (s2_az_r) begin
      if (s2_bz_r) begin
        cnt_nxt = s2_cz_r ? CNT_INF : CNT_NONE;
      end else begin
        cnt_nxt = CNT_ONE;
        lin_nxt = 1'b1;
      end
    end else if (neg_disc) begin
      cnt_nxt = CNT_NONE;
    end else if (dzero) begin
      cnt_nxt = CNT_ONE;
    end else begin
      cnt_nxt = CNT_TWO;
    end
  end

  logic          s3_valid_r;
  logic [PW-1:0] s3_q_r;
  sq_side_t      s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_q_r          <= q_nxt;
    s3_side_r.count <= cnt_nxt;
    s3_side_r.lin   <= lin_nxt;
    s3_side_r.rem2  <= s2_b2_r[1:0];
    s3_side_r.am    <= s2_am_r;
    s3_side_r.bm    <= s2_bm_r;
    s3_side_r.cm    <= s2_cm_r;
    s3_side_r.an    <= s2_an_r;
    s3_side_r.bn    <= s2_bn_r;
    s3_side_r.cn    <= s2_cn_r;
  end

  // square-root cells
  logic              sq_v    [0:W];
  logic [PW-1:0]     sq_rad  [0:W];
  logic [W-1:0]      sq_res  [0:W];
  logic [W:0]        sq_rem  [0:W];
  logic [SQ_SW-1:0]  sq_side [0:W];

  assign sq_v[0]    = s3_valid_r;
  assign sq_rad[0]  = s3_q_r;
  assign sq_res[0]  = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = s3_side_r;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    qsr_sqrt_cell #(
      .SW     (W),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (sq_v[i]),
      .rad_in   (sq_rad[i]),
      .res_in   (sq_res[i]),
      .rem_in   (sq_rem[i]),
      .side_in  (sq_side[i]),
      .v_out    (sq_v[i+1]),
      .rad_out  (sq_rad[i+1]),
      .res_out  (sq_res[i+1]),
      .rem_out  (sq_rem[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  // prep: floor sqrt of the full discriminant, numerators and divisors
  sq_side_t        sqo;
  logic [W:0]      root;
  logic            adj;
  logic signed [W+1:0] b_sig, n1, n2;
  logic [W:0]      n1m, n2m, den2a;
  logic [W:0]      num1_nxt, den1_nxt, num2_nxt, den2_nxt;
  logic            sg1_nxt, sg2_nxt;

  always_comb begin
    sqo   = sq_side_t'(sq_side[W]);
    // sqrt(4q+rem) is 2s or 2s+1, with q - s*s left in the remainder
    adj   = ((W+1)'(sq_res[W]) + (W+1)'(sqo.rem2 == 2'b00)) <= sq_rem[W];
    root  = {sq_res[W], 1'b0} + (W+1)'(adj);
    b_sig = sqo.bn ? -$signed((W+2)'(sqo.bm)) : $signed((W+2)'(sqo.bm));
    n1    = -b_sig + $signed((W+2)'(root));
    n2    = -b_sig - $signed((W+2)'(root));
    n1m   = n1[W+1] ? (W+1)'(-n1) : n1[W:0];
    n2m   = n2[W+1] ? (W+1)'(-n2) : n2[W:0];
    den2a = {sqo.am, 1'b0};
    num1_nxt = '0;
    den1_nxt = (W+1)'(1);
    sg1_nxt  = 1'b0;
    num2_nxt = '0;
    den2_nxt = (W+1)'(1);
    sg2_nxt  = 1'b0;
    case (sqo.count)
      CNT_ONE: begin
        if (sqo.lin) begin
          num1_nxt = (W+1)'(sqo.cm);
          den1_nxt = (W+1)'(sqo.bm);
          sg1_nxt  = sqo.cn != sqo.bn;
        end else begin
          num1_nxt = (W+1)'(sqo.bm);
          den1_nxt = den2a;
          sg1_nxt  = sqo.bn == sqo.an;
        end
      end
      CNT_TWO: begin
        num1_nxt = n1m;
        den1_nxt = den2a;
        sg1_nxt  = n1[W+1] != sqo.an;
        num2_nxt = n2m;
        den2_nxt = den2a;
        sg2_nxt  = n2[W+1] != sqo.an;
      end
      default: begin
      end
    endcase
  end

  logic          p_valid_r;
  logic [QW-1:0] p_num1_r, p_num2_r;
  logic [DW-1:0] p_den1_r, p_den2_r;
  dv_side_t      p_side1_r, p_side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= sq_v[W];
    end
  end

  always_ff @(posedge clk) begin
    p_num1_r        <= {num1_nxt, {FRAC_BITS{1'b0}}};
    p_num2_r        <= {num2_nxt, {FRAC_BITS{1'b0}}};
    p_den1_r        <= den1_nxt;
    p_den2_r        <= den2_nxt;
    p_side1_r.count <= sqo.count;
    p_side1_r.neg   <= sg1_nxt;
    p_side2_r.count <= sqo.count;
    p_side2_r.neg   <= sg2_nxt;
  end

  // divider cells, two rows side by side
  logic              d1_v    [0:QW];
  logic [QW-1:0]     d1_num  [0:QW];
  logic [DW-1:0]     d1_rem  [0:QW];
  logic [DW-1:0]     d1_den  [0:QW];
  logic [DV_SW-1:0]  d1_side [0:QW];
  logic              d2_v    [0:QW];
  logic [QW-1:0]     d2_num  [0:QW];
  logic [DW-1:0]     d2_rem  [0:QW];
  logic [DW-1:0]     d2_den  [0:QW];
  logic [DV_SW-1:0]  d2_side [0:QW];

  assign d1_v[0]    = p_valid_r;
  assign d1_num[0]  = p_num1_r;
  assign d1_rem[0]  = '0;
  assign d1_den[0]  = p_den1_r;
  assign d1_side[0] = p_side1_r;
  assign d2_v[0]    = p_valid_r;
  assign d2_num[0]  = p_num2_r;
  assign d2_rem[0]  = '0;
  assign d2_den[0]  = p_den2_r;
  assign d2_side[0] = p_side2_r;

  for (genvar j = 0; j < QW; j++) begin : g_div
    qsr_div_cell #(
      .NW     (QW),
      .DW     (DW),
      .SIDE_W (DV_SW)
    ) u_first (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (d1_v[j]),
      .num_in   (d1_num[j]),
      .rem_in   (d1_rem[j]),
      .den_in   (d1_den[j]),
      .side_in  (d1_side[j]),
      .v_out    (d1_v[j+1]),
      .num_out  (d1_num[j+1]),
      .rem_out  (d1_rem[j+1]),
      .den_out  (d1_den[j+1]),
      .side_out (d1_side[j+1])
    );

    qsr_div_cell #(
      .NW     (QW),
      .DW     (DW),
      .SIDE_W (DV_SW)
    ) u_second (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (d2_v[j]),
      .num_in   (d2_num[j]),
      .rem_in   (d2_rem[j]),
      .den_in   (d2_den[j]),
      .side_in  (d2_side[j]),
      .v_out    (d2_v[j+1]),
      .num_out  (d2_num[j+1]),
      .rem_out  (d2_rem[j+1]),
      .den_out  (d2_den[j+1]),
      .side_out (d2_side[j+1])
    );
  end

  // finish: saturate, zero test, output register
  dv_side_t  fo1, fo2;
  logic [W:0] fr1, fr2;
  logic       use1, use2;
  qsr_out_t   out_nxt;

  always_comb begin
    fo1  = dv_side_t'(d1_side[QW]);
    fo2  = dv_side_t'(d2_side[QW]);
    fr1  = fin_root(fo1.neg, d1_num[QW], eps_r);
    fr2  = fin_root(fo2.neg, d2_num[QW], eps_r);
    use1 = (fo1.count == CNT_ONE) || (fo1.count == CNT_TWO);
    use2 = (fo2.count == CNT_TWO) && d2_v[QW];
    out_nxt.root_count  = fo1.count;
    out_nxt.first_root  = use1 ? 32'($signed(fr1[W-1:0])) : '0;
    out_nxt.second_root = use2 ? 32'($signed(fr2[W-1:0])) : '0;
    out_nxt.overflow    = (use1 && fr1[W]) || (use2 && fr2[W]);
  end

  logic     out_valid_r;
  qsr_out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d1_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/qsr_checker.sv =====
module qsr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input qsr_pkg::qsr_in_t  in_item,
  input logic              out_valid,
  input qsr_pkg::qsr_out_t out_item,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [15:0]       cfg_data
);

  import qsr_pkg::*;

  // no roots or infinitely many: nothing to report
  a_no_root_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.root_count == CNT_NONE || out_item.root_count == CNT_INF)
    |-> out_item.first_root == '0 && out_item.second_root == '0 && !out_item.overflow)
    else $error("root values on a result without a single root");

  a_second_only_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.root_count != CNT_TWO |-> out_item.second_root == '0)
    else $error("second root set without two roots");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("item refused");

endmodule

bind quadratic_root_solver_unit qsr_checker u_qsr_checker (.*);
